// ===== rtl/mdd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mdd_pkg: shared definitions for the multiplexed decimal display
// Widths, digit count, display result type and the seven-segment glyph table.
// ----------------------------------------------------------------------------
package mdd_pkg;

    localparam int VALUE_WIDTH  = 17;
    localparam int DIGIT_COUNT  = 5;
    localparam int POS_WIDTH    = $clog2(DIGIT_COUNT + 1);
    localparam int EN_WIDTH     = 5;
    localparam int SEG_WIDTH    = 7;
    localparam int BCD_WIDTH    = 4;
    localparam int DOT_POSITION = 3;

    typedef logic [DIGIT_COUNT-1:0][BCD_WIDTH-1:0] digit_vec_t;

    typedef struct packed {
        logic [EN_WIDTH-1:0]  enable;
        logic [SEG_WIDTH-1:0] seg;
        logic                 dp;
    } display_t;

    function automatic longint unsigned pow10(input int k);
        longint unsigned acc;
        acc = 1;
        for (int i = 0; i < k; i++)
        begin
            acc = acc * 10;
        end
        return acc;
    endfunction

    function automatic logic [SEG_WIDTH-1:0] glyph(input logic [BCD_WIDTH-1:0] digit);
        logic [SEG_WIDTH-1:0] pattern;
        unique case (digit)
            4'd0:    pattern = 7'h3F;
            4'd1:    pattern = 7'h06;
            4'd2:    pattern = 7'h5B;
            4'd3:    pattern = 7'h4F;
            4'd4:    pattern = 7'h66;
            4'd5:    pattern = 7'h6D;
            4'd6:    pattern = 7'h7D;
            4'd7:    pattern = 7'h07;
            4'd8:    pattern = 7'h7F;
            4'd9:    pattern = 7'h6F;
            default: pattern = '0;
        endcase
        return pattern;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/multiplexed_decimal_display.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// multiplexed_decimal_display: multiplexed seven-segment display driver
// Each item is one refresh tick; the block shows one digit of the value per
// tick and steps its digit position after every item.
// ----------------------------------------------------------------------------
//  Channel | Handshake                 | Fields
//  --------+---------------------------+----------------------------------------
//  in      | in_valid / in_stall       | value[16:0], dot
//  out     | out_valid / out_stall     | digit_enable[4:0], segments[6:0],
//          |                           | decimal_point
//
//  An item is accepted in every cycle while in_stall is low; it passes
//  through the input register and then the result register.
//  The two register stages hold each item; the digit split and the glyph
//  lookup sit between them as combinational logic.
//  Reset clears the digit position to idle and empties both registers.
//  A stall at the output backs up through the input register to in_stall.
// ----------------------------------------------------------------------------
module multiplexed_decimal_display
    import mdd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [VALUE_WIDTH-1:0] value,
    input  wire logic                   dot,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [EN_WIDTH-1:0]         digit_enable,
    output logic [SEG_WIDTH-1:0]        segments,
    output logic                        decimal_point
);

    logic [POS_WIDTH-1:0]   pos_reg;
    logic [POS_WIDTH-1:0]   pos_next;
    logic                   s1_valid_reg;
    logic [VALUE_WIDTH-1:0] s1_value_reg;
    logic                   s1_dot_reg;
    logic [POS_WIDTH-1:0]   s1_pos_reg;
    logic                   out_valid_reg;
    display_t               out_reg;

    digit_vec_t             digits;
    display_t               disp;
    logic                   in_accept;
    logic                   s2_load;

    assign s2_load   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !s2_load;
    assign in_accept = in_valid && !in_stall;

    assign pos_next = (int'(pos_reg) >= DIGIT_COUNT) ? POS_WIDTH'(1) : pos_reg + POS_WIDTH'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                pos_reg <= pos_next;
            end
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s2_load)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s2_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_value_reg <= value;
            s1_dot_reg   <= dot;
            s1_pos_reg   <= pos_reg;
        end
        if (s2_load)
        begin
            out_reg <= disp;
        end
    end

    mdd_digit_split u_split (
        .value  (s1_value_reg),
        .digits (digits)
    );

    mdd_glyph_select u_select (
        .digits (digits),
        .pos    (s1_pos_reg),
        .dot    (s1_dot_reg),
        .disp   (disp)
    );

    assign out_valid     = out_valid_reg;
    assign digit_enable  = out_reg.enable;
    assign segments      = out_reg.seg;
    assign decimal_point = out_reg.dp;

`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(pos_reg) <= DIGIT_COUNT)
        else $error("digit position out of range");

    a_enable_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot0(digit_enable))
        else $error("more than one digit enabled");

    a_enable_has_glyph: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (digit_enable != '0)) |-> (segments != '0))
        else $error("enabled digit without a segment pattern");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |-> !(s1_valid_reg && out_valid_reg && out_stall))
        else $error("item accepted into a full pipeline");
`endif

endmodule
`default_nettype wire

// ===== rtl/mdd_digit_split.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mdd_digit_split: decimal digit extraction
// Splits the value into its low five decimal digits, most significant first,
// using one constant reciprocal multiplier per power of ten.
// ----------------------------------------------------------------------------
module mdd_digit_split
    import mdd_pkg::*;
(
    input  wire logic [VALUE_WIDTH-1:0] value,
    output digit_vec_t                  digits
);

    logic [DIGIT_COUNT:0][VALUE_WIDTH-1:0] quot;

    // The reciprocal is rounded up with enough fraction bits that the
    // quotient is exact over the whole input range.
    for (genvar k = 0; k <= DIGIT_COUNT; k++)
    begin : g_quot
        localparam longint unsigned DIV   = pow10(k);
        localparam int              SHIFT = VALUE_WIDTH + $clog2(DIV);
        localparam longint unsigned RECIP = ((64'd1 << SHIFT) + DIV - 64'd1) / DIV;
        localparam int              MW    = $clog2(RECIP + 64'd1);
        localparam int              PW    = VALUE_WIDTH + MW;

        logic [PW-1:0] prod;

        assign prod    = PW'(value) * PW'(RECIP);
        assign quot[k] = VALUE_WIDTH'(prod >> SHIFT);
    end

    for (genvar k = 0; k < DIGIT_COUNT; k++)
    begin : g_digit
        logic [VALUE_WIDTH-1:0] rem;

        assign rem = quot[k] - (quot[k+1] << 3) - (quot[k+1] << 1);
        assign digits[DIGIT_COUNT-1-k] = rem[BCD_WIDTH-1:0];
    end

endmodule
`default_nettype wire

// ===== rtl/mdd_glyph_select.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mdd_glyph_select: digit selection and segment drive
// Picks the digit at the current position, applies leading zero blanking and
// forms the enable, segment pattern and decimal point.
// ----------------------------------------------------------------------------
module mdd_glyph_select
    import mdd_pkg::*;
(
    input  wire digit_vec_t           digits,
    input  wire logic [POS_WIDTH-1:0] pos,
    input  wire logic                 dot,
    output display_t                  disp
);

    logic [BCD_WIDTH-1:0] sel_digit;
    logic                 active;
    logic                 lit;

    always_comb
    begin
        sel_digit = '0;
        active    = (pos != '0) && (int'(pos) <= DIGIT_COUNT);
        lit       = (int'(pos) == DIGIT_COUNT);
        for (int i = 0; i < DIGIT_COUNT; i++)
        begin
            if (int'(pos) == i + 1)
            begin
                sel_digit = digits[i];
            end
            if ((i + 1 <= int'(pos)) && (digits[i] != '0))
            begin
                lit = 1'b1;
            end
        end
    end

    always_comb
    begin
        disp = '0;
        if (active)
        begin
            for (int i = 0; i < EN_WIDTH; i++)
            begin
                disp.enable[i] = lit && (int'(pos) == i + 1);
            end
            disp.seg = glyph(sel_digit);
            disp.dp  = dot && (int'(pos) == DOT_POSITION);
        end
    end

endmodule
`default_nettype wire
